@@ sv/sfrs_pkg.sv @@
// Shared types, constants and chunk arithmetic for the flash request splitter.
`default_nettype none
package sfrs_pkg;

	localparam int ADDR_W        = 25;
	localparam int LEN_W         = 13;
	localparam int ID_W          = 24;
	localparam int OUT_ADDR_W    = 24;
	localparam int CNT_W         = 8;
	localparam int CAP_W         = 5;
	localparam int SUM_W         = ADDR_W + 1;

	localparam int PAGE_BYTES        = 256;
	localparam int SECTOR_BYTES      = 4096;
	localparam int MAX_REQUEST_BYTES = 4096;
	localparam int PAGE_W            = $clog2(PAGE_BYTES);
	localparam int MAX_RESULTS       = 64;
	localparam int N_W               = $clog2(MAX_RESULTS);
	localparam int QUEUE_DEPTH       = 2;
	localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] FN_IDENTIFY = 3'd0;
	localparam logic [2:0] FN_READ     = 3'd1;
	localparam logic [2:0] FN_WRITE    = 3'd2;
	localparam logic [2:0] FN_ERASE    = 3'd3;
	localparam logic [2:0] FN_SLEEP    = 3'd4;
	localparam logic [2:0] FN_WAKE     = 3'd5;

	localparam logic [7:0] OP_NONE    = 8'h00;
	localparam logic [7:0] OP_READ    = 8'h03;
	localparam logic [7:0] OP_PROGRAM = 8'h02;
	localparam logic [7:0] OP_ERASE   = 8'h20;
	localparam logic [7:0] OP_SLEEP   = 8'hB9;
	localparam logic [7:0] OP_WAKE    = 8'hAB;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NODEV   = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_UNSUPP  = 2'd3;

	localparam logic [7:0]      CAP_MIN     = 8'h10;
	localparam logic [7:0]      CAP_MAX     = 8'h19;
	localparam logic [ID_W-1:0] ID_ALL_ONES = 24'hFFFFFF;
	localparam logic [CNT_W-1:0] CHUNK_RESET = 8'd192;
	localparam logic [CNT_W-1:0] CHUNK_MAX   = 8'd252;

	typedef enum logic [1:0] {
		K_STATUS,
		K_SINGLE,
		K_READ,
		K_WRITE
	} kind_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CLASS,
		F_COUNT,
		F_PUSH
	} front_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        opcode;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  length;
		logic              flag;
		logic [1:0]        status;
		logic [CAP_W-1:0]  size_log2;
	} desc_t;

	typedef struct packed {
		logic                  has_transaction;
		logic [7:0]            opcode;
		logic [OUT_ADDR_W-1:0] address_out;
		logic [CNT_W-1:0]      byte_count;
		logic                  write_enable_first;
		logic                  wait_ready_after;
		logic [1:0]            status;
		logic                  last;
		logic [CAP_W-1:0]      size_log2_out;
	} res_t;

	function automatic logic [CNT_W-1:0] eff_limit(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] l;
		l = raw;
		if (l == '0)
			l = CNT_W'(1);
		if (l > CHUNK_MAX)
			l = CHUNK_MAX;
		return l;
	endfunction

	function automatic logic [CNT_W-1:0] chunk_len(
		input logic [ADDR_W-1:0] addr,
		input logic [LEN_W-1:0]  rem,
		input logic              is_write,
		input logic [CNT_W-1:0]  lim
	);
		logic [LEN_W-1:0] space;
		logic [LEN_W-1:0] c;
		space = LEN_W'(PAGE_BYTES) - LEN_W'(addr[PAGE_W-1:0]);
		c = rem;
		if (is_write && c > space)
			c = space;
		if (c > LEN_W'(lim))
			c = LEN_W'(lim);
		return c[CNT_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ sv/sfrs_front.sv @@
// Front end: accepts requests, checks and classifies them, counts transfer chunks.
`default_nettype none
module sfrs_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [2:0]                    func,
	input  wire logic [sfrs_pkg::ADDR_W-1:0]   address,
	input  wire logic [sfrs_pkg::LEN_W-1:0]    length,
	input  wire logic [sfrs_pkg::ID_W-1:0]     id_value,
	input  wire logic [sfrs_pkg::CNT_W-1:0]    lim,
	output logic                               q_push,
	output sfrs_pkg::desc_t                    q_data,
	input  wire logic                          q_full
);
	import sfrs_pkg::*;

	front_state_t      state_q, state_d;
	logic [CAP_W-1:0]  cap_q, cap_d;
	logic [2:0]        func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [ID_W-1:0]   id_q;
	desc_t             desc_q, desc_d;
	logic [ADDR_W-1:0] walk_addr_q, walk_addr_d;
	logic [LEN_W-1:0]  walk_rem_q, walk_rem_d;
	logic [N_W-1:0]    walk_n_q, walk_n_d;

	logic              accept;
	logic              range_bad;
	logic              erase_bad;
	logic [SUM_W-1:0]  cap_bytes;
	logic [CNT_W-1:0]  step_c;
	logic [LEN_W-1:0]  step_rem;

	assign full      = (state_q != F_IDLE);
	assign accept    = push && !full;
	assign q_data    = desc_q;
	assign cap_bytes = SUM_W'(1) << cap_q;
	assign range_bad = (len_q > LEN_W'(MAX_REQUEST_BYTES)) ||
		((SUM_W'(addr_q) + SUM_W'(len_q)) > cap_bytes);
	assign erase_bad = SUM_W'(addr_q) >= cap_bytes;
	assign step_c    = chunk_len(walk_addr_q, walk_rem_q, desc_q.kind == K_WRITE, lim);
	assign step_rem  = walk_rem_q - LEN_W'(step_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cap_q   <= '0;
		end else begin
			state_q <= state_d;
			cap_q   <= cap_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			addr_q <= address;
			len_q  <= length;
			id_q   <= id_value;
		end
		desc_q      <= desc_d;
		walk_addr_q <= walk_addr_d;
		walk_rem_q  <= walk_rem_d;
		walk_n_q    <= walk_n_d;
	end

	always_comb begin
		state_d     = state_q;
		cap_d       = cap_q;
		desc_d      = desc_q;
		walk_addr_d = walk_addr_q;
		walk_rem_d  = walk_rem_q;
		walk_n_d    = walk_n_q;
		q_push      = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (accept)
					state_d = F_CLASS;
			end
			F_CLASS: begin
				desc_d.kind      = K_STATUS;
				desc_d.opcode    = OP_NONE;
				desc_d.address   = '0;
				desc_d.length    = '0;
				desc_d.flag      = 1'b0;
				desc_d.status    = ST_OK;
				desc_d.size_log2 = cap_q;
				state_d          = F_PUSH;
				unique case (func_q) inside
					FN_IDENTIFY: begin
						if (id_q == '0 || id_q == ID_ALL_ONES) begin
							cap_d         = '0;
							desc_d.status = ST_NODEV;
						end else if (id_q[7:0] >= CAP_MIN && id_q[7:0] <= CAP_MAX) begin
							cap_d         = id_q[CAP_W-1:0];
							desc_d.status = ST_OK;
						end else begin
							cap_d         = '0;
							desc_d.status = ST_UNSUPP;
						end
						desc_d.size_log2 = cap_d;
					end
					FN_READ, FN_WRITE: begin
						if (cap_q == '0) begin
							desc_d.status = ST_NODEV;
						end else if (range_bad) begin
							desc_d.status = ST_RANGE;
						end else if (len_q != '0) begin
							desc_d.kind    = (func_q == FN_WRITE) ? K_WRITE : K_READ;
							desc_d.address = addr_q;
							desc_d.length  = len_q;
							walk_addr_d    = addr_q;
							walk_rem_d     = len_q;
							walk_n_d       = '0;
							state_d        = F_COUNT;
						end
					end
					FN_ERASE: begin
						if (cap_q == '0) begin
							desc_d.status = ST_NODEV;
						end else if (erase_bad) begin
							desc_d.status = ST_RANGE;
						end else begin
							desc_d.kind    = K_SINGLE;
							desc_d.opcode  = OP_ERASE;
							desc_d.address = addr_q & ~ADDR_W'(SECTOR_BYTES - 1);
							desc_d.flag    = 1'b1;
						end
					end
					FN_SLEEP: begin
						desc_d.kind   = K_SINGLE;
						desc_d.opcode = OP_SLEEP;
					end
					FN_WAKE: begin
						desc_d.kind   = K_SINGLE;
						desc_d.opcode = OP_WAKE;
					end
					default: begin
						state_d = F_IDLE;
					end
				endcase
			end
			F_COUNT: begin
				walk_addr_d = walk_addr_q + ADDR_W'(step_c);
				walk_rem_d  = step_rem;
				walk_n_d    = walk_n_q + N_W'(1);
				if (step_rem == '0) begin
					state_d = F_PUSH;
				end else if (walk_n_q == N_W'(MAX_RESULTS - 1)) begin
					desc_d.kind    = K_STATUS;
					desc_d.address = '0;
					desc_d.length  = '0;
					desc_d.status  = ST_RANGE;
					state_d        = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/sfrs_queue.sv @@
// Short descriptor queue between the front end and the back end.
`default_nettype none
module sfrs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire sfrs_pkg::desc_t  push_data,
	output logic                  full,
	input  wire logic             pop,
	output sfrs_pkg::desc_t       pop_data,
	output logic                  empty
);
	import sfrs_pkg::*;

	desc_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

@@ sv/sfrs_back.sv @@
// Back end: walks descriptors into command transactions and holds the result register.
`default_nettype none
module sfrs_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [sfrs_pkg::CNT_W-1:0]  lim,
	output logic                             q_pop,
	input  wire sfrs_pkg::desc_t             q_data,
	input  wire logic                        q_empty,
	output sfrs_pkg::res_t                   res,
	output logic                             empty,
	input  wire logic                        pop
);
	import sfrs_pkg::*;

	logic              active_q;
	desc_t             cur_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  rem_q;
	logic              out_valid_q;
	res_t              out_q;

	logic              emit;
	logic              is_write;
	logic [CNT_W-1:0]  c;
	logic [LEN_W-1:0]  rem_next;
	res_t              res_d;

	assign q_pop    = !active_q && !q_empty;
	assign emit     = active_q && (!out_valid_q || pop);
	assign is_write = (cur_q.kind == K_WRITE);
	assign c        = chunk_len(addr_q, rem_q, is_write, lim);
	assign rem_next = rem_q - LEN_W'(c);
	assign res      = out_q;
	assign empty    = !out_valid_q;

	always_comb begin
		res_d               = '0;
		res_d.size_log2_out = cur_q.size_log2;
		res_d.last          = 1'b1;
		unique case (cur_q.kind) inside
			K_STATUS: begin
				res_d.status = cur_q.status;
			end
			K_SINGLE: begin
				res_d.has_transaction    = 1'b1;
				res_d.opcode             = cur_q.opcode;
				res_d.address_out        = cur_q.address[OUT_ADDR_W-1:0];
				res_d.write_enable_first = cur_q.flag;
				res_d.wait_ready_after   = cur_q.flag;
			end
			K_READ, K_WRITE: begin
				res_d.has_transaction    = 1'b1;
				res_d.opcode             = is_write ? OP_PROGRAM : OP_READ;
				res_d.address_out        = addr_q[OUT_ADDR_W-1:0];
				res_d.byte_count         = c;
				res_d.write_enable_first = is_write;
				res_d.wait_ready_after   = is_write;
				res_d.last               = (rem_next == '0);
			end
			default: begin
				res_d.status = cur_q.status;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop)
				active_q <= 1'b1;
			else if (emit && res_d.last)
				active_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q  <= q_data;
			addr_q <= q_data.address;
			rem_q  <= q_data.length;
		end else if (emit) begin
			addr_q <= addr_q + ADDR_W'(c);
			rem_q  <= rem_next;
		end
		if (emit)
			out_q <= res_d;
	end

endmodule
`default_nettype wire

@@ sv/spi_nor_flash_request_splitter_unit.sv @@
// Top level: serial NOR flash request splitter, front end, descriptor queue, back end.
// Flow: the front end classifies an accepted request, counts the chunks of a read or write,
// and hands the descriptor to the queue; the back end loads it, then one result per cycle
// while pop keeps up. The front end takes no new request until its descriptor is pushed;
// a page-aligned 4096-byte write at chunk_limit 192 splits into 32 chunks.
// Reset: clears all control state, chunk_limit returns to 192, capacity to no device.
`default_nettype none
module spi_nor_flash_request_splitter_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [2:0]                        func,
	input  wire logic [sfrs_pkg::ADDR_W-1:0]       address,
	input  wire logic [sfrs_pkg::LEN_W-1:0]        length,
	input  wire logic [sfrs_pkg::ID_W-1:0]         id_value,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic                                   has_transaction,
	output logic [7:0]                             opcode,
	output logic [sfrs_pkg::OUT_ADDR_W-1:0]        address_out,
	output logic [sfrs_pkg::CNT_W-1:0]             byte_count,
	output logic                                   write_enable_first,
	output logic                                   wait_ready_after,
	output logic [1:0]                             status,
	output logic                                   last,
	output logic [sfrs_pkg::CAP_W-1:0]             size_log2_out,
	input  wire logic                              cfg_wr_en,
	input  wire logic [sfrs_pkg::CNT_W-1:0]        cfg_wr_data
);
	import sfrs_pkg::*;

	logic [CNT_W-1:0] chunk_limit_q;
	logic [CNT_W-1:0] lim;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_empty;
	desc_t            q_in;
	desc_t            q_out;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			chunk_limit_q <= CHUNK_RESET;
		else if (cfg_wr_en)
			chunk_limit_q <= cfg_wr_data;
	end

	assign lim = eff_limit(chunk_limit_q);

	sfrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.address  (address),
		.length   (length),
		.id_value (id_value),
		.lim      (lim),
		.q_push   (q_push),
		.q_data   (q_in),
		.q_full   (q_full)
	);

	sfrs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	sfrs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.lim     (lim),
		.q_pop   (q_pop),
		.q_data  (q_out),
		.q_empty (q_empty),
		.res     (res),
		.empty   (empty),
		.pop     (pop)
	);

	assign has_transaction    = res.has_transaction;
	assign opcode             = res.opcode;
	assign address_out        = res.address_out;
	assign byte_count         = res.byte_count;
	assign write_enable_first = res.write_enable_first;
	assign wait_ready_after   = res.wait_ready_after;
	assign status             = res.status;
	assign last               = res.last;
	assign size_log2_out      = res.size_log2_out;

endmodule
`default_nettype wire
